@@ hdl/wps_pkg.sv @@
// ----------------------------------------------------------------------------
// wps_pkg
// Shared types and constants of the wake power sequencer bus slave.
// ----------------------------------------------------------------------------
package wps_pkg;

  // Input request kinds.
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_BUTTON = 3'd1;
  localparam logic [2:0] KIND_START  = 3'd2;
  localparam logic [2:0] KIND_WRITE  = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // Bus command bytes.
  localparam logic [7:0] CMD_NOP_LO = 8'h64;
  localparam logic [7:0] CMD_WSEC   = 8'h66;
  localparam logic [7:0] CMD_WMIN   = 8'h67;
  localparam logic [7:0] CMD_RDIN   = 8'h69;
  localparam logic [7:0] CMD_WROUT  = 8'h70;

  // Timer constants.
  localparam logic [7:0] SECS_PER_MIN      = 8'd60;
  localparam logic [7:0] WAKE_SECS_RESET   = 8'd30;
  localparam logic [5:0] MIN_ON_RESET      = 6'd2;

  // Byte address of the min_on_sec register on the APB port.
  localparam logic [2:0] ADDR_MIN_ON = 3'd0;

  // Power phases.
  localparam logic [1:0] PHASE_OFF  = 2'd0;
  localparam logic [1:0] PHASE_MIN  = 2'd1;
  localparam logic [1:0] PHASE_HOLD = 2'd2;

  // Selected bus action.
  typedef enum logic [2:0] {
    ACT_IDLE  = 3'd0,
    ACT_STORE = 3'd1,
    ACT_WSEC  = 3'd2,
    ACT_WMIN  = 3'd3,
    ACT_RDIN  = 3'd4,
    ACT_WROUT = 3'd5,
    ACT_NOP   = 3'd6
  } action_t;

  // Store access strobes from the controller.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Result fields that travel beside the store read.
  typedef struct packed {
    logic       store_rd;
    logic [7:0] rd_byte;
    logic       power;
    logic [1:0] phase;
    logic [1:0] pins;
  } stage_t;

endpackage

@@ hdl/wake_power_sequencer_bus_slave.sv @@
// ----------------------------------------------------------------------------
// wake_power_sequencer_bus_slave
// Wake timer and power sequencer with a byte-wide bus slave command set.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the result side does not stall,
// and returns one result per request: each request passes through the
// registered read of the single-port scratch store and then the output register. A request
// that follows in the next cycle always sees the effect of the one before,
// since all control state and store writes commit at acceptance. The store
// clears at reset through per-entry valid bits, so no clearing pass is
// needed and requests are taken from the first cycle after reset. The
// min_on_sec register lies at byte address 0 of the APB port.
module wake_power_sequencer_bus_slave #(
  parameter int STORE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic        stay_awake,
  input  logic [7:0]  input_pins,
  // Result channel.
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  read_data,
  output logic        power_enable,
  output logic [1:0]  power_phase,
  output logic [1:0]  output_pins,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wps_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [5:0]    min_on_sec;
  logic          accept;
  logic          advance;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;
  stage_t        stage;
  logic          s1_valid;
  stage_t        s1;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MIN_ON) ? {26'd0, min_on_sec} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_on_sec <= MIN_ON_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_MIN_ON) begin
      min_on_sec <= pwdata[5:0];
    end
  end

  // Handshake: a store-read stage and the output register form a skid pair.
  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign accept     = item_valid && !item_stall;

  wps_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (kind),
    .data_byte  (data_byte),
    .stay_awake (stay_awake),
    .input_pins (input_pins),
    .min_on_sec (min_on_sec),
    .mem_ctl    (mem_ctl),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .stage      (stage)
  );

  wps_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        result_valid <= s1_valid;
      end
      if (!s1_valid || advance) begin
        s1_valid <= accept;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stage;
    end
    if (advance && s1_valid) begin
      read_data    <= s1.store_rd ? mem_rdata : s1.rd_byte;
      power_enable <= s1.power;
      power_phase  <= s1.phase;
      output_pins  <= s1.pins;
    end
  end

  // Power is on exactly when a phase other than off is reported.
  a_power_phase: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (power_enable == (power_phase != PHASE_OFF)))
    else $error("power_enable disagrees with power_phase");

  // The request side only stalls when both pipeline slots are full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (s1_valid && result_valid && result_stall))
    else $error("request stalled with a free slot");

  // An accepted request occupies the store-read stage in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request lost in pipeline");

endmodule

@@ hdl/wps_store.sv @@
// ----------------------------------------------------------------------------
// wps_store
// Scratch store: synchronous memory with a registered read and a
// valid bit per entry so that reset reads back as zero at once.
// ----------------------------------------------------------------------------
module wps_store #(
  parameter int STORE_DEPTH = 64,
  parameter int AW          = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  wps_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);
  import wps_pkg::*;

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid;
  logic [7:0]             mem_q;
  logic                   valid_q;

  // Memory array write and registered read.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      mem_q <= mem[addr];
    end
  end

  // Per-entry valid bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid[addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        valid_q <= valid[addr];
      end
    end
  end

  // An entry never written since reset reads as zero.
  assign rdata = valid_q ? mem_q : 8'd0;

endmodule

@@ hdl/wps_ctrl.sv @@
// ----------------------------------------------------------------------------
// wps_ctrl
// Request decoder: wake timer, power phases, bus command handling and the
// address and strobes of the scratch store.
// ----------------------------------------------------------------------------
module wps_ctrl #(
  parameter int STORE_DEPTH = 64,
  parameter int AW          = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [2:0]        kind,
  input  logic [7:0]        data_byte,
  input  logic              stay_awake,
  input  logic [7:0]        input_pins,
  input  logic [5:0]        min_on_sec,
  output wps_pkg::mem_ctl_t mem_ctl,
  output logic [AW-1:0]     mem_addr,
  output logic [7:0]        mem_wdata,
  output wps_pkg::stage_t   stage
);
  import wps_pkg::*;

  localparam logic [6:0] DEPTH7 = 7'(STORE_DEPTH);
  localparam logic [7:0] DEPTH8 = 8'(STORE_DEPTH);

  logic       cmd_seen,     cmd_seen_next;
  action_t    action,       action_next;
  logic [6:0] store_index,  store_index_next;
  logic [7:0] wake_seconds, wake_seconds_next;
  logic [7:0] wake_minutes, wake_minutes_next;
  logic [7:0] second_count, second_count_next;
  logic [7:0] minute_count, minute_count_next;
  logic [1:0] phase,        phase_next;
  logic       btn_busy,     btn_busy_next;
  logic       power,        power_next;
  logic [1:0] pins,         pins_next;

  logic [6:0] rd_index;
  logic [6:0] rd_index_inc;

  // Read index with wrap at the end of the store.
  always_comb begin
    rd_index     = (store_index < DEPTH7) ? store_index : 7'd0;
    rd_index_inc = rd_index + 7'd1;
  end

  // Next state for one request.
  always_comb begin
    cmd_seen_next     = cmd_seen;
    action_next       = action;
    store_index_next  = store_index;
    wake_seconds_next = wake_seconds;
    wake_minutes_next = wake_minutes;
    second_count_next = second_count;
    minute_count_next = minute_count;
    phase_next        = phase;
    btn_busy_next     = btn_busy;
    power_next        = power;
    pins_next         = pins;
    mem_ctl           = '0;
    mem_addr          = store_index[AW-1:0];
    mem_wdata         = data_byte;
    stage.store_rd    = 1'b0;
    stage.rd_byte     = 8'd0;

    case (kind)
      KIND_TICK: begin
        second_count_next = second_count + 8'd1;
        if (wake_minutes != 8'd0) begin
          if (second_count_next >= SECS_PER_MIN) begin
            second_count_next = 8'd0;
            minute_count_next = minute_count + 8'd1;
            if (minute_count_next >= wake_minutes) begin
              minute_count_next = 8'd0;
              phase_next        = PHASE_MIN;
              power_next        = 1'b1;
            end
          end
        end else if (second_count_next >= wake_seconds) begin
          second_count_next = 8'd0;
          phase_next        = PHASE_MIN;
          power_next        = 1'b1;
        end
        // Minimum on time elapsed: hold or release.
        if (phase_next == PHASE_MIN && second_count_next >= {2'b00, min_on_sec}) begin
          if (stay_awake) begin
            phase_next = PHASE_HOLD;
          end else begin
            phase_next    = PHASE_OFF;
            power_next    = 1'b0;
            btn_busy_next = 1'b0;
          end
        end
        if (phase_next == PHASE_HOLD && !stay_awake) begin
          phase_next    = PHASE_OFF;
          power_next    = 1'b0;
          btn_busy_next = 1'b0;
        end
      end
      KIND_BUTTON: begin
        if (!btn_busy) begin
          btn_busy_next     = 1'b1;
          second_count_next = 8'd0;
          phase_next        = PHASE_MIN;
          power_next        = 1'b1;
        end
      end
      KIND_START: begin
        cmd_seen_next = 1'b0;
      end
      KIND_WRITE: begin
        if (!cmd_seen) begin
          // First byte after a start selects the command.
          cmd_seen_next = 1'b1;
          if (data_byte < DEPTH8) begin
            action_next      = ACT_STORE;
            store_index_next = data_byte[6:0];
          end else if (data_byte == CMD_WSEC) begin
            action_next = ACT_WSEC;
          end else if (data_byte == CMD_WMIN) begin
            action_next = ACT_WMIN;
          end else if (data_byte == CMD_RDIN) begin
            action_next = ACT_RDIN;
          end else if (data_byte == CMD_WROUT) begin
            action_next = ACT_WROUT;
          end else if (data_byte >= CMD_NOP_LO && data_byte <= CMD_WROUT) begin
            action_next = ACT_NOP;
          end
        end else begin
          case (action)
            ACT_STORE: begin
              if (store_index < DEPTH7) begin
                mem_ctl.wr_en    = accept;
                store_index_next = store_index + 7'd1;
              end
            end
            ACT_WSEC: begin
              wake_seconds_next = data_byte;
              wake_minutes_next = 8'd0;
              action_next       = ACT_IDLE;
            end
            ACT_WMIN: begin
              wake_seconds_next = 8'd0;
              wake_minutes_next = data_byte;
              action_next       = ACT_IDLE;
            end
            ACT_WROUT: begin
              pins_next = data_byte[1:0];
            end
            default: begin
            end
          endcase
        end
      end
      KIND_READ: begin
        cmd_seen_next = 1'b1;
        if (action == ACT_STORE) begin
          mem_ctl.rd_en    = accept;
          mem_addr         = rd_index[AW-1:0];
          stage.store_rd   = 1'b1;
          store_index_next = (rd_index_inc >= DEPTH7) ? 7'd0 : rd_index_inc;
        end else if (action == ACT_RDIN) begin
          stage.rd_byte = input_pins;
        end
      end
      default: begin
      end
    endcase

    stage.power = power_next;
    stage.phase = phase_next;
    stage.pins  = pins_next;
  end

  // Control state registers, updated on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_seen     <= 1'b0;
      action       <= ACT_IDLE;
      store_index  <= 7'd0;
      wake_seconds <= WAKE_SECS_RESET;
      wake_minutes <= 8'd0;
      second_count <= 8'd0;
      minute_count <= 8'd0;
      phase        <= PHASE_OFF;
      btn_busy     <= 1'b0;
      power        <= 1'b0;
      pins         <= 2'd0;
    end else if (accept) begin
      cmd_seen     <= cmd_seen_next;
      action       <= action_next;
      store_index  <= store_index_next;
      wake_seconds <= wake_seconds_next;
      wake_minutes <= wake_minutes_next;
      second_count <= second_count_next;
      minute_count <= minute_count_next;
      phase        <= phase_next;
      btn_busy     <= btn_busy_next;
      power        <= power_next;
      pins         <= pins_next;
    end
  end

endmodule
